/* sv/psm_pkg.sv */
// Package for the payload signature matcher: request types, signature tables, pattern codes.
`timescale 1ns / 1ps
package psm_pkg;

  // Signature lengths and byte counter limits
  localparam int unsigned HsLen    = 6;
  localparam int unsigned HdrLen   = 7;
  localparam int unsigned SigLen   = 22;
  localparam logic [4:0]  CountMax = 5'd23;

  // Verdict codes
  localparam logic [1:0] PAT_NONE      = 2'd0;
  localparam logic [1:0] PAT_HANDSHAKE = 2'd1;
  localparam logic [1:0] PAT_HEADER    = 2'd2;
  localparam logic [1:0] PAT_STRING    = 2'd3;

  // Six-byte handshake
  localparam logic [7:0] HS_SIG [HsLen] = '{8'h7F, 8'h7F, 8'h49, 8'h43, 8'h41, 8'h00};

  // Seven-byte header prefix
  localparam logic [7:0] HDR_SIG [HdrLen] = '{8'h1A, 8'h43, 8'h47, 8'h50, 8'h2F, 8'h30,
                                              8'h31};

  // Embedded proxy-service string, first byte oldest
  localparam logic [7:0] STR_SIG [SigLen] = '{
    8'h43, 8'h69, 8'h74, 8'h72, 8'h69, 8'h78, 8'h2E, 8'h54, 8'h63, 8'h70, 8'h50,
    8'h72, 8'h6F, 8'h78, 8'h79, 8'h53, 8'h65, 8'h72, 8'h76, 8'h69, 8'h63, 8'h65
  };

  // Input request
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_packet;
    logic       empty_packet;
  } psm_in_t;

  // Result request
  typedef struct packed {
    logic       is_match;
    logic [1:0] which_pattern;
  } psm_out_t;

  // One scan step handed to the scanner
  typedef struct packed {
    logic       fire;
    logic [7:0] data;
    logic       last;
    logic       empty;
  } psm_step_t;

  // Scanner response for the current step
  typedef struct packed {
    logic       produce;
    logic       is_match;
    logic [1:0] which;
  } psm_res_t;

endpackage

/* sv/psm_scan.sv */
// Per-packet scan state and verdict logic for the payload signature matcher.
`timescale 1ns / 1ps
module psm_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  psm_pkg::psm_step_t step,
  output psm_pkg::psm_res_t  res
);
  import psm_pkg::*;

  logic [4:0] count_r, count_nxt;
  logic       hs_ok_r, hs_ok_nxt;
  logic       hdr_ok_r, hdr_ok_nxt;
  logic       found_r, found_nxt;
  logic       zero_r, zero_nxt;
  logic [7:0] win_r [SigLen];
  logic       win_hit;
  logic       clear;

  // Window compare: last 21 stored bytes plus the incoming one
  always_comb begin
    win_hit = (step.data == STR_SIG[SigLen-1]);
    for (int i = 0; i < SigLen - 1; i++) begin
      win_hit = win_hit && (win_r[i+1] == STR_SIG[i]);
    end
  end

  // Next state and verdict for this byte
  always_comb begin
    hs_ok_nxt  = hs_ok_r;
    hdr_ok_nxt = hdr_ok_r;
    if (count_r < 5'(HsLen) && step.data != HS_SIG[count_r[2:0]]) begin
      hs_ok_nxt = 1'b0;
    end
    if (count_r < 5'(HdrLen) && step.data != HDR_SIG[count_r[2:0]]) begin
      hdr_ok_nxt = 1'b0;
    end
    zero_nxt  = zero_r || (step.data == 8'h00);
    found_nxt = found_r || (!zero_nxt && count_r >= 5'(SigLen - 1) && win_hit);
    count_nxt = (count_r < CountMax) ? count_r + 5'd1 : count_r;

    res.produce  = step.fire && (step.last || step.empty);
    res.which    = PAT_NONE;
    if (!step.empty) begin
      priority if (count_nxt == 5'(HsLen) && hs_ok_nxt) begin
        res.which = PAT_HANDSHAKE;
      end else if (count_nxt == CountMax && hdr_ok_nxt) begin
        res.which = PAT_HEADER;
      end else if (count_nxt == CountMax && found_nxt) begin
        res.which = PAT_STRING;
      end else begin
        res.which = PAT_NONE;
      end
    end
    res.is_match = (res.which != PAT_NONE);
    clear        = step.last || step.empty;
  end

  // Control state: counter and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      hs_ok_r  <= 1'b1;
      hdr_ok_r <= 1'b1;
      found_r  <= 1'b0;
      zero_r   <= 1'b0;
    end else if (step.fire) begin
      if (clear) begin
        count_r  <= '0;
        hs_ok_r  <= 1'b1;
        hdr_ok_r <= 1'b1;
        found_r  <= 1'b0;
        zero_r   <= 1'b0;
      end else begin
        count_r  <= count_nxt;
        hs_ok_r  <= hs_ok_nxt;
        hdr_ok_r <= hdr_ok_nxt;
        found_r  <= found_nxt;
        zero_r   <= zero_nxt;
      end
    end
  end

  // Byte history; only read once 21 bytes of this packet are in it
  always_ff @(posedge clk) begin
    if (step.fire && !step.empty) begin
      for (int i = 0; i < SigLen - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[SigLen-1] <= step.data;
    end
  end

  // A match never comes from an empty packet
  a_empty_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    (step.fire && step.empty) |-> !res.is_match)
    else $error("empty packet reported a match");

  // Counter never passes its saturation value
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountMax)
    else $error("byte counter beyond saturation");

  // After a packet end the scan state is back to its initial values
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step.fire && clear) |=> (count_r == 5'd0 && hs_ok_r && hdr_ok_r && !found_r && !zero_r))
    else $error("scan state not cleared after packet end");

endmodule

/* sv/payload_signature_matcher_top.sv */
// Top level of the payload signature matcher: input register, scanner, result register.
//
//  channel | direction | payload              | handshake
//  in_     | input     | psm_in_t (10 bits)   | in_valid / in_ready
//  out_    | output    | psm_out_t (3 bits)   | out_valid / out_ready
//
// One byte per cycle sustained while the result register does not stall; a verdict
// passes from the last byte's accepted request through the input register, then the
// scanner logic, into the result register; the per-byte scanner update sets the rate.
// rst_n is synchronous, active low, and clears all control state; no clearing pass.
// A stalled result holds the input register only while that register has work waiting.
`timescale 1ns / 1ps
module payload_signature_matcher_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psm_pkg::psm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output psm_pkg::psm_out_t out_data
);
  import psm_pkg::*;

  logic      in_valid_r;
  psm_in_t   in_data_r;
  logic      out_valid_r;
  psm_out_t  out_data_r;
  logic      stall;
  logic      adv;
  psm_step_t step;
  psm_res_t  res;

  // Stall only when the result register is full and not being taken
  assign stall    = out_valid_r && !out_ready;
  assign adv      = in_valid_r && !stall;
  assign in_ready = !in_valid_r || !stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  assign step.fire  = adv;
  assign step.data  = in_data_r.payload_byte;
  assign step.last  = in_data_r.last_of_packet;
  assign step.empty = in_data_r.empty_packet;

  psm_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!stall) begin
      out_valid_r <= res.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && res.produce) begin
      out_data_r.is_match      <= res.is_match;
      out_data_r.which_pattern <= res.which;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Match flag agrees with the pattern code
  a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_match == (out_data_r.which_pattern != PAT_NONE)))
    else $error("match flag and pattern code disagree");

  // A new result only follows a step that ends a packet
  a_rose_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && (in_data_r.last_of_packet || in_data_r.empty_packet)))
    else $error("result appeared without a packet end");

  // Empty register always takes a new request
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input stalled while its register is empty");

endmodule
